### rtl/core/bloom_filter_8way_prime_mod_top_defines.svh
// ---------------------------------------------------------------------------
// bloom filter assertion macros
// shared property wrappers for the bloom filter core
// ---------------------------------------------------------------------------
`ifndef BLOOM_FILTER_8WAY_PRIME_MOD_TOP_DEFINES_SVH
`define BLOOM_FILTER_8WAY_PRIME_MOD_TOP_DEFINES_SVH

// same-cycle implication, checked on aclk outside reset
`define BFPM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define BFPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/bfpm_pkg.sv
// ---------------------------------------------------------------------------
// bfpm_pkg
// shared types and constants of the bloom filter core
// ---------------------------------------------------------------------------
`default_nettype none

package bfpm_pkg;

    localparam int FILTER_SIZE = 65536;
    localparam int IDX_W       = 16;
    localparam int ROW_W       = 32;
    localparam int BIT_W       = 5;
    localparam int ROWS        = FILTER_SIZE / ROW_W;
    localparam int ADDR_W      = IDX_W - BIT_W;
    localparam int HASH_W      = 128;
    localparam int WORD_W      = 16;

    // reduction primes, probe p uses entry 7-p
    localparam logic [WORD_W-1:0] PROBE_PRIME [8] = '{
        16'd65353, 16'd65357, 16'd65371, 16'd65381,
        16'd65393, 16'd65407, 16'd65413, 16'd65419
    };

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [ROW_W-1:0]  wdata;
    } ram_req_t;

endpackage

`default_nettype wire

### rtl/core/bfpm_reduce.sv
// ---------------------------------------------------------------------------
// bfpm_reduce
// picks one hash word and reduces it by its prime into a bit index
// ---------------------------------------------------------------------------
`default_nettype none

module bfpm_reduce
    import bfpm_pkg::*;
(
    input  logic [HASH_W-1:0] hash,
    input  logic [2:0]        probe,
    output logic [IDX_W-1:0]  idx
);

    logic [2:0]        word_slot;
    logic [2:0]        prime_sel;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] prime;

    // probe p takes word 15-p: hash_high sits in slots 3..0, hash_mid in 7..4,
    // so the slot is 3-p modulo 8; the prime is entry 7-p
    // word is below 2*prime, so one conditional subtract is the remainder
    always_comb begin
        word_slot = 3'd3 - probe;
        prime_sel = 3'd7 - probe;
        word      = hash[{word_slot, 4'b0000} +: WORD_W];
        prime     = PROBE_PRIME[prime_sel];
        idx       = (word >= prime) ? (word - prime) : word;
    end

endmodule

`default_nettype wire

### rtl/core/bfpm_ram.sv
// ---------------------------------------------------------------------------
// bfpm_ram
// single-port filter bit store, one row per access, registered read
// ---------------------------------------------------------------------------
`default_nettype none

module bfpm_ram
    import bfpm_pkg::*;
(
    input  logic             aclk,
    input  ram_req_t         req,
    output logic [ROW_W-1:0] rdata
);

    logic [ROW_W-1:0] mem [ROWS];

    always_ff @(posedge aclk) begin
        if (req.en) begin
            if (req.we) begin
                mem[req.addr] <= req.wdata;
            end else begin
                rdata <= mem[req.addr];
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/bloom_filter_8way_prime_mod_top.sv
// ---------------------------------------------------------------------------
// bloom_filter_8way_prime_mod_top
// bloom filter over a 65536-bit store, probes reduced by fixed primes
// ---------------------------------------------------------------------------
//
// channel  | dir | contents
// ---------+-----+------------------------------------------------------------
// s_axis   | in  | tuser: mode, tdata: hash_high, hash_mid
// m_axis   | out | tdata: all_present, search_total, hit_total
//
// an item passes an accept state, then a read and a check state per probe (read,
// then check and optional write back on the single-port store)
// after reset a clearing pass writes zeros over all 2048 store rows, one
// row a cycle, with s_tready low during it
// a result waiting on m_tready holds the core once the next item is done
// ---------------------------------------------------------------------------
`default_nettype none

`include "bloom_filter_8way_prime_mod_top_defines.svh"

module bloom_filter_8way_prime_mod_top
    import bfpm_pkg::*;
#(
    parameter int NUM_PROBES = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input items
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // hash_high [63:0], hash_mid [127:64]
    input  wire logic         s_tuser,   // mode (0 query, 1 insert)
    // results
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [71:0]       m_tdata    // all_present [0], search_total [32:1],
                                         // hit_total [64:33], zero [71:65]
);

    localparam int PW = (NUM_PROBES > 1) ? $clog2(NUM_PROBES) : 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_HOLD
    } state_t;

    state_t            state_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic [PW-1:0]     probe_reg;
    logic [HASH_W-1:0] hash_reg;
    logic              ins_reg;
    logic [ADDR_W-1:0] row_reg;
    logic [BIT_W-1:0]  bitpos_reg;
    logic              all_reg;
    logic              m_tvalid_reg;
    logic              out_all_reg;
    logic [31:0]       search_reg;
    logic [31:0]       hit_reg;

    logic [IDX_W-1:0]  idx;
    logic [ROW_W-1:0]  rd_data;
    ram_req_t          ram_req;
    logic              cur_bit;
    logic              all_now;
    logic              last_probe;
    logic              out_free;
    logic              load_out;
    logic              load_all;

    // bit index of the current probe
    bfpm_reduce u_reduce (
        .hash  (hash_reg),
        .probe (3'(probe_reg)),
        .idx   (idx)
    );

    bfpm_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (rd_data)
    );

    // a bit set by an earlier probe of the same insert was clear before it,
    // so all_present is already false and the plain and of reads is exact
    always_comb begin
        cur_bit    = rd_data[bitpos_reg];
        all_now    = all_reg & cur_bit;
        last_probe = (probe_reg == PW'(NUM_PROBES - 1));
        out_free   = !m_tvalid_reg || m_tready;
        load_out   = out_free && ((state_reg == ST_CHECK && last_probe) ||
                                  state_reg == ST_HOLD);
        load_all   = (state_reg == ST_CHECK) ? all_now : all_reg;
    end

    // store access per state
    always_comb begin
        ram_req = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_req.en    = 1'b1;
                ram_req.we    = 1'b1;
                ram_req.addr  = clr_reg;
                ram_req.wdata = '0;
            end
            ST_READ: begin
                ram_req.en    = 1'b1;
                ram_req.addr  = idx[IDX_W-1:BIT_W];
            end
            ST_CHECK: begin
                // write back only when an insert finds the bit clear
                ram_req.en    = ins_reg && !cur_bit;
                ram_req.we    = 1'b1;
                ram_req.addr  = row_reg;
                ram_req.wdata = rd_data | (ROW_W'(1) << bitpos_reg);
            end
            default: begin
                ram_req = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            search_reg   <= '0;
            hit_reg      <= '0;
        end else begin
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
                out_all_reg  <= load_all;
                search_reg   <= search_reg + 32'd1;
                hit_reg      <= hit_reg + 32'(load_all);
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + ADDR_W'(1);
                    if (clr_reg == ADDR_W'(ROWS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        hash_reg  <= s_tdata;
                        ins_reg   <= s_tuser;
                        probe_reg <= '0;
                        all_reg   <= 1'b1;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    row_reg    <= idx[IDX_W-1:BIT_W];
                    bitpos_reg <= idx[BIT_W-1:0];
                    state_reg  <= ST_CHECK;
                end
                ST_CHECK: begin
                    all_reg <= all_now;
                    if (last_probe) begin
                        state_reg <= out_free ? ST_IDLE : ST_HOLD;
                    end else begin
                        probe_reg <= probe_reg + PW'(1);
                        state_reg <= ST_READ;
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, hit_reg, search_reg, out_all_reg};

    `BFPM_ASSERT_NEXT(a_accept_starts_probe, s_tvalid && s_tready,
        state_reg == ST_READ && probe_reg == '0,
        "accepted transfer did not start probing")
    `BFPM_ASSERT_IMPL(a_query_never_writes, ram_req.en && ram_req.we,
        state_reg == ST_CLEAR || ins_reg,
        "store written outside clear or insert")
    `BFPM_ASSERT_NEXT(a_search_counts_once, load_out,
        search_reg == $past(search_reg) + 32'd1,
        "search count not advanced by one")
    `BFPM_ASSERT_IMPL(a_hold_has_result, state_reg == ST_HOLD, m_tvalid_reg,
        "holding without a pending result")

endmodule

`default_nettype wire
